/* sv/fapem_pkg.sv */
package fapem_pkg;

    // Default geometry of the array.
    localparam int DEF_SECTOR_BYTES = 256;
    localparam int DEF_SECTOR_COUNT = 16;
    localparam int DEF_MAX_BURST    = 64;

    // Configuration port.
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_LOCKED   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_NOTIFY_ENABLE = 1'b1;

    // Value of an erased cell.
    localparam logic [7:0] ERASED = 8'hFF;

    typedef enum logic [1:0] {
        KIND_INIT  = 2'd0,
        KIND_READ  = 2'd1,
        KIND_PROG  = 2'd2,
        KIND_ERASE = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_PARAM      = 2'd1,
        ST_REGION     = 2'd2,
        ST_NOT_ERASED = 2'd3
    } t_status;

    // Status flags from the datapath to the controller.
    typedef struct packed {
        t_kind   kind;
        logic    first;
        t_status sticky;
        logic    len_zero;
        logic    region_ok;
        logic    erase_ok;
        logic    sweep_done;
        logic    burst_last;
        logic    prog_empty;
        logic    prog_aborted;
        logic    cell_ok;
        logic    init_locked;
        logic    notify_enable;
    } t_dp_status;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    capture;
        logic    sweep_all;
        logic    sweep_erase;
        logic    sweep_step;
        logic    burst_load;
        logic    burst_step;
        logic    prog_open;
        logic    prog_close;
        logic    prog_clear_all;
        logic    prog_fetch;
        logic    prog_commit;
        logic    sticky_wr;
        t_status sticky_val;
        logic    emit;
        t_status emit_status;
        logic    emit_notify;
    } t_dp_cmd;

endpackage

/* sv/fapem_dp.sv */
module fapem_dp #(
    parameter int SECTOR_BYTES = fapem_pkg::DEF_SECTOR_BYTES,
    parameter int SECTOR_COUNT = fapem_pkg::DEF_SECTOR_COUNT,
    parameter int MAX_BURST    = fapem_pkg::DEF_MAX_BURST
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [fapem_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [fapem_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic [1:0]                       i_kind,
    input  logic [15:0]                      i_address,
    input  logic [15:0]                      i_length,
    input  logic [7:0]                       i_sector,
    input  logic                             i_first_byte,
    input  logic [7:0]                       i_data,
    input  fapem_pkg::t_dp_cmd               i_cmd,
    output fapem_pkg::t_dp_status            o_stat,
    output logic                             o_valid,
    output logic [1:0]                       o_status,
    output logic [7:0]                       o_read_data,
    output logic                             o_data_valid,
    output logic                             o_last,
    output logic                             o_error_notify,
    output logic [1:0]                       o_stored_state
);

    localparam int FLASH_BYTES = SECTOR_BYTES * SECTOR_COUNT;
    localparam int ADDR_W      = $clog2(FLASH_BYTES);
    localparam int CTR_W       = ADDR_W + 1;
    localparam int RG_W        = (CTR_W > 17) ? CTR_W : 17;
    localparam int BURST_W     = $clog2(MAX_BURST + 1);

    // Captured item.
    fapem_pkg::t_kind r_kind;
    logic [15:0]      r_addr;
    logic [15:0]      r_len;
    logic [7:0]       r_sec;
    logic             r_first;
    logic [7:0]       r_data;

    // Sweep and burst address counter.
    logic [CTR_W-1:0]   r_ctr;
    logic [CTR_W-1:0]   r_end;
    logic [BURST_W-1:0] r_cnt;

    // Program transfer state and sticky error.
    logic [CTR_W-1:0]     r_ptr;
    logic [15:0]          r_rem;
    logic                 r_abort;
    fapem_pkg::t_status   r_sticky;
    fapem_pkg::t_status   n_sticky;

    // Configuration registers.
    logic r_locked;
    logic r_notify_en;

    // Flash array with registered read.
    logic [7:0]        r_mem [FLASH_BYTES];
    logic [7:0]        r_mem_q;
    logic              r_rd_pend;
    logic              r_rd_last;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_wa;
    logic [7:0]        mem_wd;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_ra;

    // Output register.
    logic       r_o_valid;
    logic [1:0] r_o_status;
    logic [7:0] r_o_read_data;
    logic       r_o_data_valid;
    logic       r_o_last;
    logic       r_o_notify;
    logic [1:0] r_o_stored;

    // Checks on the captured item.
    logic [16:0]      sec_end;
    logic [CTR_W-1:0] erase_base;
    logic [CTR_W-1:0] erase_top;
    logic             region_ok;
    logic             erase_ok;
    logic             cell_ok;
    logic             sweep_done;

    assign sec_end    = {9'b0, r_sec} + {1'b0, r_len};
    assign erase_base = CTR_W'(r_sec) * CTR_W'(SECTOR_BYTES);
    assign erase_top  = CTR_W'(sec_end) * CTR_W'(SECTOR_BYTES);
    assign region_ok  = (RG_W'(r_addr) + RG_W'(r_len)) <= RG_W'(FLASH_BYTES);
    assign erase_ok   = (17'(r_sec) < 17'(SECTOR_COUNT)) && (sec_end <= 17'(SECTOR_COUNT));
    assign cell_ok    = (r_ptr < CTR_W'(FLASH_BYTES)) && (r_mem_q == fapem_pkg::ERASED);
    assign sweep_done = (r_ctr == r_end);

    always_comb begin
        o_stat.kind          = r_kind;
        o_stat.first         = r_first;
        o_stat.sticky        = r_sticky;
        o_stat.len_zero      = (r_len == 16'd0);
        o_stat.region_ok     = region_ok;
        o_stat.erase_ok      = erase_ok;
        o_stat.sweep_done    = sweep_done;
        o_stat.burst_last    = (r_cnt == BURST_W'(1));
        o_stat.prog_empty    = (r_rem == 16'd0);
        o_stat.prog_aborted  = r_abort;
        o_stat.cell_ok       = cell_ok;
        o_stat.init_locked   = r_locked;
        o_stat.notify_enable = r_notify_en;
    end

    // Capture the item on its transfer.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_kind  <= fapem_pkg::t_kind'(i_kind);
            r_addr  <= i_address;
            r_len   <= i_length;
            r_sec   <= i_sector;
            r_first <= i_first_byte;
            r_data  <= i_data;
        end
    end

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_locked    <= 1'b0;
            r_notify_en <= 1'b0;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == fapem_pkg::CFG_INIT_LOCKED) begin
                r_locked <= i_cfg_data[0];
            end
            if (i_cfg_idx == fapem_pkg::CFG_NOTIFY_ENABLE) begin
                r_notify_en <= i_cfg_data[0];
            end
        end
    end

    // Sweep range and burst counter.
    always_ff @(posedge i_clk) begin
        priority if (i_cmd.sweep_all) begin
            r_ctr <= '0;
            r_end <= CTR_W'(FLASH_BYTES);
        end else if (i_cmd.sweep_erase) begin
            r_ctr <= erase_base;
            r_end <= erase_top;
        end else if (i_cmd.sweep_step) begin
            r_ctr <= r_ctr + CTR_W'(1);
        end else if (i_cmd.burst_load) begin
            r_ctr <= CTR_W'(r_addr);
            r_cnt <= (r_len > 16'(MAX_BURST)) ? BURST_W'(MAX_BURST) : BURST_W'(r_len);
        end else if (i_cmd.burst_step) begin
            r_ctr <= r_ctr + CTR_W'(1);
            r_cnt <= r_cnt - BURST_W'(1);
        end else begin
            r_ctr <= r_ctr;
        end
    end

    // Program transfer state; the transfer closes when its length runs out.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr   <= '0;
            r_rem   <= '0;
            r_abort <= 1'b0;
        end else begin
            priority if (i_cmd.prog_clear_all) begin
                r_ptr   <= '0;
                r_rem   <= '0;
                r_abort <= 1'b0;
            end else if (i_cmd.prog_open) begin
                r_ptr   <= CTR_W'(r_addr);
                r_rem   <= r_len;
                r_abort <= 1'b0;
            end else if (i_cmd.prog_close) begin
                r_rem   <= '0;
                r_abort <= 1'b0;
            end else if (i_cmd.prog_commit) begin
                if (!r_abort && cell_ok) begin
                    r_ptr <= r_ptr + CTR_W'(1);
                end
                r_rem   <= r_rem - 16'd1;
                r_abort <= (r_rem == 16'd1) ? 1'b0 : (r_abort || !cell_ok);
            end else begin
                r_rem <= r_rem;
            end
        end
    end

    // Sticky error state.
    assign n_sticky = i_cmd.sticky_wr ? i_cmd.sticky_val : r_sticky;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sticky <= fapem_pkg::ST_OK;
        end else begin
            r_sticky <= n_sticky;
        end
    end

    // Memory port selection.
    always_comb begin
        mem_we = i_cmd.sweep_step || (i_cmd.prog_commit && !r_abort && cell_ok);
        mem_wa = i_cmd.sweep_step ? r_ctr[ADDR_W-1:0] : r_ptr[ADDR_W-1:0];
        mem_wd = i_cmd.sweep_step ? fapem_pkg::ERASED : r_data;
        mem_re = i_cmd.burst_step || i_cmd.prog_fetch;
        if (i_cmd.burst_step) begin
            mem_ra = r_ctr[ADDR_W-1:0];
        end else if (r_first) begin
            mem_ra = ADDR_W'(r_addr);
        end else begin
            mem_ra = r_ptr[ADDR_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            r_mem_q <= r_mem[mem_ra];
        end
    end

    // Read pipeline marker.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_pend <= 1'b0;
            r_rd_last <= 1'b0;
        end else begin
            r_rd_pend <= i_cmd.burst_step;
            r_rd_last <= o_stat.burst_last;
        end
    end

    // Result register: single results from the controller or read bytes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else begin
            r_o_valid <= i_cmd.emit || r_rd_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_o_status     <= i_cmd.emit_status;
            r_o_read_data  <= 8'd0;
            r_o_data_valid <= 1'b0;
            r_o_last       <= 1'b1;
            r_o_notify     <= i_cmd.emit_notify;
            r_o_stored     <= n_sticky;
        end else begin
            r_o_status     <= fapem_pkg::ST_OK;
            r_o_read_data  <= r_mem_q;
            r_o_data_valid <= 1'b1;
            r_o_last       <= r_rd_last;
            r_o_notify     <= 1'b0;
            r_o_stored     <= r_sticky;
        end
    end

    assign o_valid        = r_o_valid;
    assign o_status       = r_o_status;
    assign o_read_data    = r_o_read_data;
    assign o_data_valid   = r_o_data_valid;
    assign o_last         = r_o_last;
    assign o_error_notify = r_o_notify;
    assign o_stored_state = r_o_stored;

    // A single result never meets a read byte in the result register.
    a_no_result_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cmd.emit && r_rd_pend))
        else $error("single result collides with a read byte");

    // The sweep never writes past its end.
    a_sweep_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.sweep_step |-> !sweep_done)
        else $error("sweep step beyond range end");

    // A program byte is only taken into an open transfer.
    a_commit_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.prog_commit |-> (r_rem != 16'd0))
        else $error("program byte committed with no open transfer");

endmodule

/* sv/fapem_ctrl.sv */
module fapem_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  fapem_pkg::t_dp_status i_stat,
    output fapem_pkg::t_dp_cmd    o_cmd,
    output logic                  o_busy
);

    typedef enum logic [2:0] {
        S_RST_LOAD,
        S_CLEAR,
        S_IDLE,
        S_DECIDE,
        S_READ,
        S_PROG_WR,
        S_SWEEP
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_busy;
    logic   sticky_err;

    assign sticky_err = (i_stat.sticky != fapem_pkg::ST_OK);

    // Next state and commands.
    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        unique case (r_state)
            S_RST_LOAD: begin
                o_cmd.sweep_all = 1'b1;
                n_state         = S_CLEAR;
            end
            S_CLEAR: begin
                if (i_stat.sweep_done) begin
                    n_state = S_IDLE;
                end else begin
                    o_cmd.sweep_step = 1'b1;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_DECIDE;
                end
            end
            S_DECIDE: begin
                n_state = S_IDLE;
                unique case (i_stat.kind)
                    fapem_pkg::KIND_INIT: begin
                        if (i_stat.init_locked) begin
                            o_cmd.emit        = 1'b1;
                            o_cmd.emit_status = fapem_pkg::ST_PARAM;
                        end else begin
                            o_cmd.sweep_all      = 1'b1;
                            o_cmd.prog_clear_all = 1'b1;
                            o_cmd.sticky_wr      = 1'b1;
                            o_cmd.sticky_val     = fapem_pkg::ST_OK;
                            n_state              = S_SWEEP;
                        end
                    end
                    fapem_pkg::KIND_READ: begin
                        if (sticky_err) begin
                            o_cmd.emit        = 1'b1;
                            o_cmd.emit_status = fapem_pkg::ST_OK;
                        end else if (i_stat.len_zero) begin
                            o_cmd.sticky_wr   = 1'b1;
                            o_cmd.sticky_val  = fapem_pkg::ST_PARAM;
                            o_cmd.emit        = 1'b1;
                            o_cmd.emit_status = fapem_pkg::ST_PARAM;
                            o_cmd.emit_notify = i_stat.notify_enable;
                        end else if (!i_stat.region_ok) begin
                            o_cmd.sticky_wr   = 1'b1;
                            o_cmd.sticky_val  = fapem_pkg::ST_REGION;
                            o_cmd.emit        = 1'b1;
                            o_cmd.emit_status = fapem_pkg::ST_REGION;
                        end else begin
                            o_cmd.burst_load = 1'b1;
                            n_state          = S_READ;
                        end
                    end
                    fapem_pkg::KIND_PROG: begin
                        if (sticky_err) begin
                            o_cmd.emit        = 1'b1;
                            o_cmd.emit_status = fapem_pkg::ST_OK;
                        end else if (i_stat.first && i_stat.len_zero) begin
                            o_cmd.sticky_wr   = 1'b1;
                            o_cmd.sticky_val  = fapem_pkg::ST_PARAM;
                            o_cmd.prog_close  = 1'b1;
                            o_cmd.emit        = 1'b1;
                            o_cmd.emit_status = fapem_pkg::ST_PARAM;
                        end else if (i_stat.first && !i_stat.region_ok) begin
                            o_cmd.sticky_wr   = 1'b1;
                            o_cmd.sticky_val  = fapem_pkg::ST_REGION;
                            o_cmd.prog_close  = 1'b1;
                            o_cmd.emit        = 1'b1;
                            o_cmd.emit_status = fapem_pkg::ST_REGION;
                        end else begin
                            o_cmd.prog_open  = i_stat.first;
                            o_cmd.prog_fetch = 1'b1;
                            n_state          = S_PROG_WR;
                        end
                    end
                    fapem_pkg::KIND_ERASE: begin
                        if (sticky_err) begin
                            o_cmd.emit        = 1'b1;
                            o_cmd.emit_status = i_stat.sticky;
                        end else if (!i_stat.erase_ok) begin
                            o_cmd.sticky_wr   = 1'b1;
                            o_cmd.sticky_val  = fapem_pkg::ST_PARAM;
                            o_cmd.emit        = 1'b1;
                            o_cmd.emit_status = fapem_pkg::ST_PARAM;
                        end else begin
                            o_cmd.sweep_erase = 1'b1;
                            n_state           = S_SWEEP;
                        end
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_READ: begin
                o_cmd.burst_step = 1'b1;
                if (i_stat.burst_last) begin
                    n_state = S_IDLE;
                end
            end
            S_PROG_WR: begin
                // The addressed cell is in the read register now.
                n_state    = S_IDLE;
                o_cmd.emit = 1'b1;
                if (i_stat.prog_empty) begin
                    o_cmd.emit_status = fapem_pkg::ST_OK;
                end else begin
                    o_cmd.prog_commit = 1'b1;
                    if (i_stat.prog_aborted || !i_stat.cell_ok) begin
                        o_cmd.emit_status = fapem_pkg::ST_NOT_ERASED;
                    end else begin
                        o_cmd.emit_status = fapem_pkg::ST_OK;
                    end
                end
            end
            S_SWEEP: begin
                if (i_stat.sweep_done) begin
                    o_cmd.emit        = 1'b1;
                    o_cmd.emit_status = fapem_pkg::ST_OK;
                    n_state           = S_IDLE;
                end else begin
                    o_cmd.sweep_step = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and busy flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_RST_LOAD;
            r_busy  <= 1'b1;
        end else begin
            r_state <= n_state;
            r_busy  <= (n_state != S_IDLE);
        end
    end

    assign o_busy = r_busy;

    // An accepted item is decided in the next cycle.
    a_capture_decide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.capture |=> (r_state == S_DECIDE))
        else $error("accepted item not decided");

    // The busy flag is low exactly when the controller waits for an item.
    a_busy_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy == (r_state != S_IDLE))
        else $error("busy flag out of step with state");

    // A program write always follows the fetch of its cell.
    a_prog_after_fetch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PROG_WR) |-> ($past(r_state) == S_DECIDE))
        else $error("program write without cell fetch");

endmodule

/* sv/flash_array_program_erase_model.sv */
// Channel      Direction  Ports                                     Handshake
// command      in         i_kind i_address i_length i_sector        start high, busy low
//                         i_first_byte i_data
// result       out        o_status o_read_data o_data_valid o_last  o_valid, one cycle
//                         o_error_notify o_stored_state
// config       in         i_cfg_idx i_cfg_data                      i_cfg_we
//
// After reset the array is cleared to 0xFF in one pass over all SECTOR_BYTES*SECTOR_COUNT cells
// with busy high. A program byte is decided, its cell fetched through the array read port
// and then written through the write port. Bytes of a read burst leave one a cycle, paced
// by the array read port. Init rewrites the whole array and erase length*SECTOR_BYTES cells,
// one cell rewritten per cycle. Results cannot be stalled.
module flash_array_program_erase_model #(
    parameter int SECTOR_BYTES = fapem_pkg::DEF_SECTOR_BYTES,
    parameter int SECTOR_COUNT = fapem_pkg::DEF_SECTOR_COUNT,
    parameter int MAX_BURST    = fapem_pkg::DEF_MAX_BURST
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [1:0]                       i_kind,
    input  logic [15:0]                      i_address,
    input  logic [15:0]                      i_length,
    input  logic [7:0]                       i_sector,
    input  logic                             i_first_byte,
    input  logic [7:0]                       i_data,
    input  logic                             i_cfg_we,
    input  logic [fapem_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [fapem_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output logic                             o_valid,
    output logic [1:0]                       o_status,
    output logic [7:0]                       o_read_data,
    output logic                             o_data_valid,
    output logic                             o_last,
    output logic                             o_error_notify,
    output logic [1:0]                       o_stored_state
);

    fapem_pkg::t_dp_cmd    cmd;
    fapem_pkg::t_dp_status stat;

    // Sequencer.
    fapem_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    // Array, transfer state and result register.
    fapem_dp #(
        .SECTOR_BYTES (SECTOR_BYTES),
        .SECTOR_COUNT (SECTOR_COUNT),
        .MAX_BURST    (MAX_BURST)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_kind         (i_kind),
        .i_address      (i_address),
        .i_length       (i_length),
        .i_sector       (i_sector),
        .i_first_byte   (i_first_byte),
        .i_data         (i_data),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .o_valid        (o_valid),
        .o_status       (o_status),
        .o_read_data    (o_read_data),
        .o_data_valid   (o_data_valid),
        .o_last         (o_last),
        .o_error_notify (o_error_notify),
        .o_stored_state (o_stored_state)
    );

endmodule

/* tb/flash_array_program_erase_model_test.sv */
module flash_array_program_erase_model_test;

    localparam int SECTOR_BYTES = fapem_pkg::DEF_SECTOR_BYTES;
    localparam int SECTOR_COUNT = fapem_pkg::DEF_SECTOR_COUNT;
    localparam int MAX_BURST    = fapem_pkg::DEF_MAX_BURST;
    localparam int FLASH_BYTES  = SECTOR_BYTES * SECTOR_COUNT;

    // One result as it leaves the block.
    typedef struct packed {
        fapem_pkg::t_status status;
        logic [7:0]         read_data;
        logic               data_valid;
        logic               last;
        logic               error_notify;
        fapem_pkg::t_status stored_state;
    } t_flash_result;

    logic                             i_clk = 1'b0;
    logic                             i_rst_n = 1'b0;
    logic                             start = 1'b0;
    logic                             busy;
    logic [1:0]                       i_kind = fapem_pkg::KIND_INIT;
    logic [15:0]                      i_address = '0;
    logic [15:0]                      i_length = '0;
    logic [7:0]                       i_sector = '0;
    logic                             i_first_byte = 1'b0;
    logic [7:0]                       i_data = '0;
    logic                             i_cfg_we = 1'b0;
    logic [fapem_pkg::CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [fapem_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                             o_valid;
    logic [1:0]                       o_status;
    logic [7:0]                       o_read_data;
    logic                             o_data_valid;
    logic                             o_last;
    logic                             o_error_notify;
    logic [1:0]                       o_stored_state;

    // Predicted contents of the array and the block's control state.
    logic [7:0]         model_cells [FLASH_BYTES];
    fapem_pkg::t_status model_sticky = fapem_pkg::ST_OK;
    int                 prog_ptr = 0;
    int                 prog_left = 0;
    bit                 prog_aborted = 1'b0;
    bit                 cfg_locked = 1'b0;
    bit                 cfg_notify = 1'b0;

    t_flash_result awaited_results[$];
    t_flash_result next_result;

    int error_count = 0;
    int results_checked = 0;
    int cmds_sent = 0;
    int init_count = 0;
    int read_count = 0;
    int prog_count = 0;
    int erase_count = 0;
    bit steady_run = 1'b0;

    flash_array_program_erase_model uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_kind         (i_kind),
        .i_address      (i_address),
        .i_length       (i_length),
        .i_sector       (i_sector),
        .i_first_byte   (i_first_byte),
        .i_data         (i_data),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .o_valid        (o_valid),
        .o_status       (o_status),
        .o_read_data    (o_read_data),
        .o_data_valid   (o_data_valid),
        .o_last         (o_last),
        .o_error_notify (o_error_notify),
        .o_stored_state (o_stored_state)
    );

    always #2 i_clk = ~i_clk;

    task automatic report_error(input string msg);
        if (error_count < 40) begin
            $display("ERROR at %0t: %s", $time, msg);
        end
        error_count++;
    endtask

    // Predictor of the array.

    function automatic void erase_cells(input int from, input int count);
        int k;
        for (k = from; k < from + count; k++) begin
            model_cells[k] = fapem_pkg::ERASED;
        end
    endfunction

    function automatic bit fits_array(input int addr, input int len);
        return addr <= FLASH_BYTES && len <= FLASH_BYTES - addr;
    endfunction

    function automatic void push_result(input fapem_pkg::t_status st, input logic [7:0] rd,
                                        input logic dv, input logic fin,
                                        input logic note);
        t_flash_result r;
        r.status       = st;
        r.read_data    = rd;
        r.data_valid   = dv;
        r.last         = fin;
        r.error_notify = note;
        r.stored_state = model_sticky;
        awaited_results.push_back(r);
    endfunction

    // Works out the results of one accepted command and updates the predicted state.
    function automatic void model_command(input fapem_pkg::t_kind kind, input int addr,
                                          input int len, input int sector, input bit first,
                                          input logic [7:0] data);
        int n;
        int i;
        fapem_pkg::t_status st;
        case (kind)
            fapem_pkg::KIND_INIT: begin
                if (cfg_locked) begin
                    push_result(fapem_pkg::ST_PARAM, 8'h00, 1'b0, 1'b1, 1'b0);
                end else begin
                    erase_cells(0, FLASH_BYTES);
                    model_sticky = fapem_pkg::ST_OK;
                    prog_ptr = 0;
                    prog_left = 0;
                    prog_aborted = 1'b0;
                    push_result(fapem_pkg::ST_OK, 8'h00, 1'b0, 1'b1, 1'b0);
                end
            end
            fapem_pkg::KIND_READ: begin
                if (model_sticky != fapem_pkg::ST_OK) begin
                    push_result(fapem_pkg::ST_OK, 8'h00, 1'b0, 1'b1, 1'b0);
                end else if (len == 0) begin
                    model_sticky = fapem_pkg::ST_PARAM;
                    push_result(fapem_pkg::ST_PARAM, 8'h00, 1'b0, 1'b1, cfg_notify);
                end else if (!fits_array(addr, len)) begin
                    model_sticky = fapem_pkg::ST_REGION;
                    push_result(fapem_pkg::ST_REGION, 8'h00, 1'b0, 1'b1, 1'b0);
                end else begin
                    n = (len > MAX_BURST) ? MAX_BURST : len;
                    for (i = 0; i < n; i++) begin
                        push_result(fapem_pkg::ST_OK, model_cells[addr + i], 1'b1,
                                    i == n - 1, 1'b0);
                    end
                end
            end
            fapem_pkg::KIND_PROG: begin
                if (model_sticky != fapem_pkg::ST_OK) begin
                    push_result(fapem_pkg::ST_OK, 8'h00, 1'b0, 1'b1, 1'b0);
                    return;
                end
                if (first) begin
                    if (len == 0 || !fits_array(addr, len)) begin
                        model_sticky = (len == 0) ? fapem_pkg::ST_PARAM : fapem_pkg::ST_REGION;
                        prog_left = 0;
                        prog_aborted = 1'b0;
                        push_result(model_sticky, 8'h00, 1'b0, 1'b1, 1'b0);
                        return;
                    end
                    prog_ptr = addr;
                    prog_left = len;
                    prog_aborted = 1'b0;
                end
                if (prog_left == 0) begin
                    push_result(fapem_pkg::ST_OK, 8'h00, 1'b0, 1'b1, 1'b0);
                    return;
                end
                st = fapem_pkg::ST_OK;
                if (prog_aborted) begin
                    st = fapem_pkg::ST_NOT_ERASED;
                end else if (prog_ptr < FLASH_BYTES &&
                             model_cells[prog_ptr] == fapem_pkg::ERASED) begin
                    model_cells[prog_ptr] = data;
                    prog_ptr++;
                end else begin
                    prog_aborted = 1'b1;
                    st = fapem_pkg::ST_NOT_ERASED;
                end
                prog_left--;
                if (prog_left == 0) begin
                    prog_aborted = 1'b0;
                end
                push_result(st, 8'h00, 1'b0, 1'b1, 1'b0);
            end
            default: begin
                if (model_sticky != fapem_pkg::ST_OK) begin
                    push_result(model_sticky, 8'h00, 1'b0, 1'b1, 1'b0);
                end else if (sector >= SECTOR_COUNT || len > SECTOR_COUNT - sector) begin
                    model_sticky = fapem_pkg::ST_PARAM;
                    push_result(fapem_pkg::ST_PARAM, 8'h00, 1'b0, 1'b1, 1'b0);
                end else begin
                    erase_cells(sector * SECTOR_BYTES, len * SECTOR_BYTES);
                    push_result(fapem_pkg::ST_OK, 8'h00, 1'b0, 1'b1, 1'b0);
                end
            end
        endcase
    endfunction

    // Result checker: every strobed result must match the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (awaited_results.size() == 0) begin
                report_error($sformatf("result with nothing awaited, status %0d", o_status));
            end else begin
                next_result = awaited_results.pop_front();
                results_checked++;
                if (o_status !== next_result.status) begin
                    report_error($sformatf("status %0d, predicted %0d",
                                           o_status, next_result.status));
                end
                if (o_read_data !== next_result.read_data) begin
                    report_error($sformatf("read_data %h, predicted %h",
                                           o_read_data, next_result.read_data));
                end
                if (o_data_valid !== next_result.data_valid) begin
                    report_error($sformatf("data_valid %b, predicted %b",
                                           o_data_valid, next_result.data_valid));
                end
                if (o_last !== next_result.last) begin
                    report_error($sformatf("last %b, predicted %b",
                                           o_last, next_result.last));
                end
                if (o_error_notify !== next_result.error_notify) begin
                    report_error($sformatf("error_notify %b, predicted %b",
                                           o_error_notify, next_result.error_notify));
                end
                if (o_stored_state !== next_result.stored_state) begin
                    report_error($sformatf("stored_state %0d, predicted %0d",
                                           o_stored_state, next_result.stored_state));
                end
            end
        end
    end

    // Sender idle time: mostly short, a few long, none during a steady run.
    function automatic int draw_gap();
        int r;
        if (steady_run) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // Sends one command and waits for its transfer; start stays high when no gap follows.
    task automatic send_cmd(input fapem_pkg::t_kind kind, input int addr, input int len,
                            input int sector, input bit first, input logic [7:0] data);
        int gap;
        start        <= 1'b1;
        i_kind       <= kind;
        i_address    <= addr[15:0];
        i_length     <= len[15:0];
        i_sector     <= sector[7:0];
        i_first_byte <= first;
        i_data       <= data;
        do begin
            @(posedge i_clk);
        end while (busy !== 1'b0);
        model_command(kind, addr & 16'hFFFF, len & 16'hFFFF, sector & 8'hFF, first, data);
        cmds_sent++;
        case (kind)
            fapem_pkg::KIND_INIT: init_count++;
            fapem_pkg::KIND_READ: read_count++;
            fapem_pkg::KIND_PROG: prog_count++;
            default:              erase_count++;
        endcase
        gap = draw_gap();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Holds the sender until every predicted result has come and the block is idle.
    task automatic wait_quiet();
        start <= 1'b0;
        do begin
            @(posedge i_clk);
        end while (awaited_results.size() != 0 || busy !== 1'b0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [fapem_pkg::CFG_IDX_W-1:0] idx,
                             input logic [fapem_pkg::CFG_DATA_W-1:0] value);
        wait_quiet();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        if (idx == fapem_pkg::CFG_INIT_LOCKED) begin
            cfg_locked = value[0];
        end else begin
            cfg_notify = value[0];
        end
    endtask

    // Address for a transfer of len bytes; mostly small windows so that cells collide.
    function automatic int pick_address(input int len);
        int r;
        r = $urandom_range(0, 9);
        if (r < 7) begin
            return $urandom_range(0, 3) * SECTOR_BYTES + $urandom_range(0, 47);
        end else if (r < 9) begin
            return $urandom_range(0, FLASH_BYTES - len);
        end
        return FLASH_BYTES - len;
    endfunction

    // Burst truncation, the inclusive upper bound and the sticky error gate.
    task automatic test_read_paths();
        send_cmd(fapem_pkg::KIND_READ, 100, 70, 0, 1'b0, 8'h00);
        send_cmd(fapem_pkg::KIND_READ, FLASH_BYTES - 64, 64, 0, 1'b0, 8'h00);
        send_cmd(fapem_pkg::KIND_READ, 0, 0, 0, 1'b0, 8'h00);
        send_cmd(fapem_pkg::KIND_ERASE, 0, 1, 0, 1'b0, 8'h00);
        send_cmd(fapem_pkg::KIND_PROG, 0, 1, 0, 1'b1, 8'h00);
        send_cmd(fapem_pkg::KIND_INIT, 0, 0, 0, 1'b0, 8'h00);
        send_cmd(fapem_pkg::KIND_READ, FLASH_BYTES - 64, 65, 0, 1'b0, 8'h00);
    endtask

    // Locked init keeps the sticky error; notify follows a zero-length read.
    task automatic test_register_effects();
        write_reg(fapem_pkg::CFG_INIT_LOCKED, 1'b1);
        send_cmd(fapem_pkg::KIND_INIT, 0, 0, 0, 1'b0, 8'h00);
        write_reg(fapem_pkg::CFG_INIT_LOCKED, 1'b0);
        write_reg(fapem_pkg::CFG_NOTIFY_ENABLE, 1'b1);
        send_cmd(fapem_pkg::KIND_INIT, 0, 0, 0, 1'b0, 8'h00);
        send_cmd(fapem_pkg::KIND_READ, 0, 0, 0, 1'b0, 8'h00);
        send_cmd(fapem_pkg::KIND_INIT, 0, 0, 0, 1'b0, 8'h00);
    endtask

    // Programming at the top cell, stray bytes, non-erased cells, restarts and bad starts.
    task automatic test_program_paths();
        send_cmd(fapem_pkg::KIND_PROG, FLASH_BYTES - 2, 2, 0, 1'b1, 8'h00);
        send_cmd(fapem_pkg::KIND_PROG, 0, 0, 0, 1'b0, 8'hFF);
        send_cmd(fapem_pkg::KIND_PROG, 0, 0, 0, 1'b0, 8'h5A);
        send_cmd(fapem_pkg::KIND_PROG, FLASH_BYTES - 2, 2, 0, 1'b1, 8'h12);
        send_cmd(fapem_pkg::KIND_PROG, 0, 0, 0, 1'b0, 8'h34);
        send_cmd(fapem_pkg::KIND_PROG, 0, 3, 0, 1'b1, 8'hA5);
        send_cmd(fapem_pkg::KIND_PROG, 1, 1, 0, 1'b1, 8'h3C);
        send_cmd(fapem_pkg::KIND_READ, 0, 3, 0, 1'b0, 8'h00);
        send_cmd(fapem_pkg::KIND_PROG, 0, 0, 0, 1'b1, 8'h77);
        send_cmd(fapem_pkg::KIND_INIT, 0, 0, 0, 1'b0, 8'h00);
        send_cmd(fapem_pkg::KIND_PROG, 65535, 65535, 255, 1'b1, 8'hFF);
        send_cmd(fapem_pkg::KIND_INIT, 0, 0, 0, 1'b0, 8'h00);
    endtask

    // Sector erase: single, empty, out of range and the whole array.
    task automatic test_erase_paths();
        send_cmd(fapem_pkg::KIND_PROG, 0, 2, 0, 1'b1, 8'h81);
        send_cmd(fapem_pkg::KIND_PROG, 0, 0, 0, 1'b0, 8'h18);
        send_cmd(fapem_pkg::KIND_ERASE, 0, 1, 0, 1'b0, 8'h00);
        send_cmd(fapem_pkg::KIND_READ, 0, 4, 0, 1'b0, 8'h00);
        send_cmd(fapem_pkg::KIND_ERASE, 0, 0, 3, 1'b0, 8'h00);
        send_cmd(fapem_pkg::KIND_ERASE, 0, 7, 10, 1'b0, 8'h00);
        send_cmd(fapem_pkg::KIND_INIT, 0, 0, 0, 1'b0, 8'h00);
        send_cmd(fapem_pkg::KIND_ERASE, 0, 65535, 255, 1'b0, 8'h00);
        send_cmd(fapem_pkg::KIND_INIT, 0, 0, 0, 1'b0, 8'h00);
        send_cmd(fapem_pkg::KIND_ERASE, 0, SECTOR_COUNT, 0, 1'b0, 8'h00);
    endtask

    // Mostly well-formed transfers with random content, plus noise and broken sequences.
    task automatic test_random_traffic(input int target);
        int goal;
        int pick;
        int len;
        int addr;
        int sector;
        int extra;
        int i;
        goal = cmds_sent + target;
        while (cmds_sent < goal) begin
            if ($urandom_range(0, 19) == 0) begin
                steady_run = !steady_run;
            end
            pick = $urandom_range(0, 99);
            if (model_sticky != fapem_pkg::ST_OK && pick < 70) begin
                send_cmd(fapem_pkg::KIND_INIT, $urandom_range(0, 65535), 0, 0, 1'b0, 8'h00);
            end else if (pick < 35) begin
                // Program transfer, sometimes cut short or followed by a stray byte.
                len = $urandom_range(1, 8);
                addr = pick_address(len);
                send_cmd(fapem_pkg::KIND_PROG, addr, len, $urandom_range(0, 255), 1'b1,
                         8'($urandom_range(0, 255)));
                extra = len - 1;
                case ($urandom_range(0, 9))
                    0: extra = $urandom_range(0, len - 1);
                    1: extra = len;
                    default: ;
                endcase
                for (i = 0; i < extra; i++) begin
                    send_cmd(fapem_pkg::KIND_PROG, $urandom_range(0, 65535),
                             $urandom_range(0, 65535), $urandom_range(0, 255), 1'b0,
                             8'($urandom_range(0, 255)));
                end
            end else if (pick < 65) begin
                case ($urandom_range(0, 9))
                    0:       len = $urandom_range(65, 80);
                    1, 2:    len = $urandom_range(17, 64);
                    default: len = $urandom_range(1, 16);
                endcase
                send_cmd(fapem_pkg::KIND_READ, pick_address(len), len,
                         $urandom_range(0, 255), 1'b0, 8'($urandom_range(0, 255)));
            end else if (pick < 78) begin
                sector = $urandom_range(0, SECTOR_COUNT - 1);
                if ($urandom_range(0, 9) == 0) begin
                    len = $urandom_range(0, SECTOR_COUNT - sector);
                end else begin
                    len = $urandom_range(0, (SECTOR_COUNT - sector < 2) ? 1 : 2);
                end
                send_cmd(fapem_pkg::KIND_ERASE, $urandom_range(0, 65535), len, sector, 1'b0,
                         8'($urandom_range(0, 255)));
            end else if (pick < 81) begin
                send_cmd(fapem_pkg::KIND_INIT, 0, 0, 0, 1'b0, 8'h00);
            end else if (pick < 84) begin
                wait_quiet();
            end else begin
                send_cmd(fapem_pkg::t_kind'($urandom_range(0, 3)), $urandom_range(0, 65535),
                         $urandom_range(0, 65535), $urandom_range(0, 255),
                         1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
            end
        end
        steady_run = 1'b0;
    endtask

    // Main sequence.
    initial begin
        int waited;
        erase_cells(0, FLASH_BYTES);
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_read_paths();
        test_register_effects();
        test_program_paths();
        test_erase_paths();
        test_random_traffic(100);
        write_reg(fapem_pkg::CFG_NOTIFY_ENABLE, 1'b0);
        test_random_traffic(100);

        // Let the last results drain, with a bound.
        start <= 1'b0;
        for (waited = 0; waited < 10000 && (awaited_results.size() != 0 || busy !== 1'b0);
             waited++) begin
            @(posedge i_clk);
        end
        repeat (20) @(posedge i_clk);
        if (awaited_results.size() != 0) begin
            report_error($sformatf("%0d predicted results never came",
                                   awaited_results.size()));
        end

        $display("Covered %0d commands (%0d init, %0d read, %0d program, %0d erase),",
                 cmds_sent, init_count, read_count, prog_count, erase_count);
        $display("%0d results checked across locked, notify and plain register settings.",
                 results_checked);
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // Run limit, several times the slowest correct run.
    initial begin
        #16000000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
